// File: sv/lfpd_pkg.sv
package lfpd_pkg;

	localparam int FRAME_BYTES = 58;
	localparam int POINTS_PER_FRAME = 16;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int ADDR_W = POS_W + 1;
	localparam int VCNT_W = $clog2(POINTS_PER_FRAME + 1);
	localparam int PIDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
	localparam int DIV_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] HDR0 = 8'hA5;
	localparam logic [7:0] HDR1 = 8'h5A;
	localparam logic [7:0] LEN_BYTE = 8'(FRAME_BYTES);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] START_POS = POS_W'(5);
	localparam logic [POS_W-1:0] STOP_POS = POS_W'(FRAME_BYTES - 3);
	localparam logic [POS_W-1:0] PT_POS = POS_W'(7);
	localparam logic [POS_W-1:0] PT_STRIDE = POS_W'(3);
	localparam logic [PIDX_W-1:0] LAST_PT = PIDX_W'(POINTS_PER_FRAME - 1);

	localparam logic [15:0] BAD_WORD = 16'hFFFF;
	localparam logic [15:0] FULL_TURN = 16'd36000;
	localparam logic [15:0] SCAN_LO = 16'd500;
	localparam logic [15:0] SCAN_HI = 16'd35500;
	localparam logic [15:0] MAX_RANGE_RST = 16'd30000;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR1,
		PH_LEN,
		PH_BODY
	} phase_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ANG_RD,
		BK_ANG_CAP,
		BK_END_CAP,
		BK_CNT_RD,
		BK_CNT_CHK,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_RAW,
		BK_INT,
		BK_CALC
	} back_state_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic push;
		logic bank;
	} tok_push_t;

	typedef struct packed {
		logic avail;
		logic full;
		logic bank;
	} tok_head_t;

	function automatic logic [15:0] fold_once(input logic [15:0] a);
		return (a > FULL_TURN) ? a - FULL_TURN : a;
	endfunction

endpackage

// File: sv/lidar_frame_point_decoder.sv
// Serial bytes enter one per beat and are assembled into one of two frame banks; a
// frame needs A5 5A, a length byte of 58 and a matching 8-bit sum, otherwise it is
// dropped without output. The input takes a byte every cycle and only stalls while
// both banks hold checked frames that are still being emitted. Each good frame
// yields 16 point beats, the last with tlast set. For each frame the back end picks up
// a checked frame, fetches the angles, counts valid points over the two store read
// ports and runs the iterative span divider. It then does two store reads and one
// compute step for each point, and any output stall holds it.
module lidar_frame_point_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // byte_in
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,  // range_mm, intensity, angle_cdeg
	output logic [1:0]                       m_tuser,  // point_valid, scan_start
	output logic                             m_tlast,  // last_point
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);
	import lfpd_pkg::*;

	store_wr_t  wr;
	tok_push_t  tok;
	tok_head_t  head;
	logic       pop;

	lfpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.head     (head),
		.wr       (wr),
		.tok      (tok)
	);

	lfpd_tokq u_tokq (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.pop    (pop),
		.head   (head)
	);

	lfpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: sv/lfpd_front.sv
module lfpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // byte_in
	input  lfpd_pkg::tok_head_t   head,
	output lfpd_pkg::store_wr_t   wr,
	output lfpd_pkg::tok_push_t   tok
);
	import lfpd_pkg::*;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  cnt_q;
	logic [7:0]        sum_q;
	logic              wbank_q;
	logic              accept;
	logic              keep;
	logic              good;

	assign s_tready = !head.full;
	assign accept = s_tvalid && s_tready;
	assign good = (s_tdata == sum_q);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: if (s_tdata == HDR0) phase_d = PH_HDR1;
				PH_HDR1: phase_d = (s_tdata == HDR1) ? PH_LEN : PH_HUNT;
				PH_LEN:  phase_d = (s_tdata == LEN_BYTE) ? PH_BODY : PH_HUNT;
				PH_BODY: if (cnt_q == LAST_POS) phase_d = PH_HUNT;
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_comb begin
		keep = 1'b0;
		tok.push = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: keep = (s_tdata == HDR0);
				PH_HDR1: keep = (s_tdata == HDR1);
				PH_LEN:  keep = (s_tdata == LEN_BYTE);
				PH_BODY: begin
					keep = (cnt_q != LAST_POS);
					tok.push = (cnt_q == LAST_POS) && good;
				end
				default: keep = 1'b0;
			endcase
		end
		tok.bank = wbank_q;
		wr.we = keep;
		wr.addr = {wbank_q, (phase_q == PH_HUNT) ? POS_W'(0) : cnt_q};
		wr.data = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q <= '0;
			sum_q <= '0;
			wbank_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_HUNT && keep) begin
				cnt_q <= POS_W'(1);
				sum_q <= s_tdata;
			end else if (keep) begin
				cnt_q <= cnt_q + POS_W'(1);
				sum_q <= sum_q + s_tdata;
			end
			if (tok.push) begin
				wbank_q <= !wbank_q;
			end
		end
	end

endmodule

// File: sv/lfpd_tokq.sv
module lfpd_tokq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfpd_pkg::tok_push_t   tok,
	input  logic                  pop,
	output lfpd_pkg::tok_head_t   head
);
	import lfpd_pkg::*;

	logic        bank_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;

	assign head.avail = (cnt_q != 2'd0);
	assign head.full = (cnt_q == 2'd2);
	assign head.bank = bank_q[rptr_q];

	always_ff @(posedge clk) begin
		if (tok.push) begin
			bank_q[wptr_q] <= tok.bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (tok.push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			unique case ({tok.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("frame queue count out of range");
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!(tok.push && head.full)) else $error("frame pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head.avail)) else $error("frame popped from an empty queue");

endmodule

// File: sv/lfpd_div.sv
module lfpd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lfpd_pkg::DIV_W-1:0]     dividend,
	input  logic [lfpd_pkg::VCNT_W-1:0]    divisor,
	output logic                           done,
	output logic [lfpd_pkg::DIV_W-1:0]     quotient
);
	import lfpd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic                  zero_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]      quo_q;
	logic [VCNT_W-1:0]     rem_q;
	logic [VCNT_W-1:0]     dvs_q;
	logic [VCNT_W:0]       trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits = (trial >= {1'b0, dvs_q});
	assign done = done_q;
	assign quotient = zero_q ? '0 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				zero_q <= (divisor == '0);
				cnt_q <= DIV_CNT_W'(DIV_W);
				quo_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[DIV_W-2:0], fits};
				rem_q <= fits ? VCNT_W'(trial - {1'b0, dvs_q}) : trial[VCNT_W-1:0];
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: sv/lfpd_back.sv
module lfpd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lfpd_pkg::store_wr_t              wr,
	input  lfpd_pkg::tok_head_t              head,
	output logic                             pop,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,  // range_mm, intensity, angle_cdeg
	output logic [1:0]                       m_tuser,  // point_valid, scan_start
	output logic                             m_tlast   // last_point
);
	import lfpd_pkg::*;

	logic [7:0]         store_q [2**ADDR_W];
	logic [7:0]         rd0_q;
	logic [7:0]         rd1_q;
	logic [POS_W-1:0]   pos0;
	logic [POS_W-1:0]   pos1;

	back_state_t        state_q, state_d;
	logic [PIDX_W-1:0]  pt_q;
	logic [POS_W-1:0]   ptr_q;
	logic [VCNT_W-1:0]  vcnt_q;
	logic [15:0]        start_ang_q;
	logic [15:0]        stop_ang_q;
	logic [15:0]        step_q;
	logic [15:0]        acc_q;
	logic [15:0]        raw_q;
	logic [15:0]        last_angle_q;
	logic [15:0]        min_range_q;
	logic [15:0]        max_range_q;

	logic               out_valid_q;
	logic [15:0]        out_range_q;
	logic [7:0]         out_inten_q;
	logic [15:0]        out_angle_q;
	logic               out_ok_q;
	logic               out_sstart_q;
	logic               out_last_q;

	logic               load;
	logic               div_start;
	logic               div_done;
	logic [15:0]        div_quo;
	logic [15:0]        span;
	logic [15:0]        rd_word;
	logic               ok;
	logic               sstart;
	logic [16:0]        acc_sum;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			store_q[wr.addr] <= wr.data;
		end
		rd0_q <= store_q[{head.bank, pos0}];
		rd1_q <= store_q[{head.bank, pos1}];
	end

	assign rd_word = {rd0_q, rd1_q};
	assign span = (start_ang_q > stop_ang_q)
		? 16'(17'(stop_ang_q) + 17'(FULL_TURN) - 17'(start_ang_q))
		: stop_ang_q - start_ang_q;

	lfpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span),
		.divisor  (vcnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:     if (head.avail) state_d = BK_ANG_RD;
			BK_ANG_RD:   state_d = BK_ANG_CAP;
			BK_ANG_CAP:  state_d = BK_END_CAP;
			BK_END_CAP:  state_d = BK_CNT_RD;
			BK_CNT_RD:   state_d = BK_CNT_CHK;
			BK_CNT_CHK:  state_d = (pt_q == LAST_PT) ? BK_DIV_GO : BK_CNT_RD;
			BK_DIV_GO:   state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: if (div_done) state_d = BK_RAW;
			BK_RAW:      state_d = BK_INT;
			BK_INT:      state_d = BK_CALC;
			BK_CALC:     if (load) state_d = (pt_q == LAST_PT) ? BK_IDLE : BK_RAW;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pos0 = ptr_q;
		pos1 = ptr_q + POS_W'(1);
		load = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_ANG_RD: begin
				pos0 = START_POS;
				pos1 = START_POS + POS_W'(1);
			end
			BK_ANG_CAP: begin
				pos0 = STOP_POS;
				pos1 = STOP_POS + POS_W'(1);
			end
			BK_DIV_GO: div_start = 1'b1;
			BK_INT: pos0 = ptr_q + POS_W'(2);
			BK_CALC: begin
				pos0 = ptr_q + POS_W'(2);
				load = !out_valid_q || m_tready;
			end
			default: ;
		endcase
		pop = load && (pt_q == LAST_PT);
	end

	assign ok = (raw_q != BAD_WORD);
	assign sstart = (acc_q < last_angle_q) && (acc_q < SCAN_LO) && (last_angle_q > SCAN_HI);
	assign acc_sum = {1'b0, acc_q} + {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pt_q <= '0;
			ptr_q <= PT_POS;
			vcnt_q <= '0;
			start_ang_q <= '0;
			stop_ang_q <= '0;
			step_q <= '0;
			acc_q <= '0;
			raw_q <= '0;
			last_angle_q <= '0;
			min_range_q <= '0;
			max_range_q <= MAX_RANGE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_MIN_RANGE) begin
				min_range_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_MAX_RANGE) begin
				max_range_q <= cfg_data;
			end
			unique case (state_q)
				BK_ANG_CAP: start_ang_q <= fold_once(rd_word);
				BK_END_CAP: begin
					stop_ang_q <= fold_once(rd_word);
					pt_q <= '0;
					ptr_q <= PT_POS;
					vcnt_q <= '0;
				end
				BK_CNT_CHK: begin
					if (rd_word != BAD_WORD) begin
						vcnt_q <= vcnt_q + VCNT_W'(1);
					end
					pt_q <= pt_q + PIDX_W'(1);
					ptr_q <= ptr_q + PT_STRIDE;
				end
				BK_DIV_WAIT: begin
					step_q <= div_quo;
					acc_q <= start_ang_q;
					pt_q <= '0;
					ptr_q <= PT_POS;
				end
				BK_INT: raw_q <= rd_word;
				BK_CALC: begin
					if (load) begin
						last_angle_q <= acc_q;
						acc_q <= (acc_sum > {1'b0, FULL_TURN})
							? 16'(acc_sum - {1'b0, FULL_TURN}) : acc_sum[15:0];
						pt_q <= pt_q + PIDX_W'(1);
						ptr_q <= ptr_q + PT_STRIDE;
					end
				end
				default: ;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_range_q <= (ok && raw_q >= min_range_q && raw_q <= max_range_q) ? raw_q : '0;
			out_inten_q <= ok ? rd0_q : '0;
			out_angle_q <= acc_q;
			out_ok_q <= ok;
			out_sstart_q <= sstart;
			out_last_q <= (pt_q == LAST_PT);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_angle_q, out_inten_q, out_range_q};
	assign m_tuser = {out_sstart_q, out_ok_q};
	assign m_tlast = out_last_q;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_angle_q <= FULL_TURN) else $error("point angle beyond a full turn");
	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= VCNT_W'(POINTS_PER_FRAME)) else $error("valid point count overflow");
	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == BK_IDLE) else $error("frame released before its last point");

endmodule
